// File: design/rotary_joint_stall_homing_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stall homing joint checks
// Each macro attaches one clocked property with reset disable.
// ----------------------------------------------------------------------------
`ifndef ROTARY_JOINT_STALL_HOMING_ASSERT_SVH
`define ROTARY_JOINT_STALL_HOMING_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RJSH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RJSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rjsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjsh_pkg
// Shared types, codes and helpers of the rotary joint stall homing block.
// ----------------------------------------------------------------------------
package rjsh_pkg;

	typedef enum logic [1:0] {
		CMD_HOME  = 2'd0,
		CMD_MOVE  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_SEARCH = 2'd1,
		ST_DISC   = 2'd2,
		ST_PARK   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MSEL_ZERO   = 2'd0,
		MSEL_SEARCH = 2'd1,
		MSEL_MAP    = 2'd2
	} msel_t;

	typedef enum logic [2:0] {
		REG_SEARCH_STEP   = 3'd0,
		REG_STALLED_STEP  = 3'd1,
		REG_TORQUE_THRESH = 3'd2,
		REG_STALL_TOL     = 3'd3,
		REG_HOME_DIR      = 3'd4,
		REG_CW_LIMIT      = 3'd5,
		REG_CCW_LIMIT     = 3'd6,
		REG_LIMIT_MARGIN  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [30:0] search_step;
		logic [30:0] stalled_step;
		logic [30:0] torque_threshold;
		logic [30:0] stall_tolerance;
		logic        home_direction;
		logic [30:0] cw_limit;
		logic [30:0] ccw_limit;
		logic [30:0] limit_margin;
	} cfg_t;

	// One classified word handed from the front end to the back end.
	typedef struct packed {
		cmd_t               kind;
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] search_motor;
		logic signed [33:0] rel;
		logic signed [33:0] pos_off;
	} q_entry_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic signed [31:0] INIT_SPEED = 32'sd65536000;

	localparam logic [30:0] RST_SEARCH_STEP   = 31'd6554;
	localparam logic [30:0] RST_STALLED_STEP  = 31'd936;
	localparam logic [30:0] RST_TORQUE_THRESH = 31'd65536;
	localparam logic [30:0] RST_STALL_TOL     = 31'd3277;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -35'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

// File: design/rotary_joint_stall_homing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_joint_stall_homing
// Stall-detect homing and body/motor frame mapping for one rotary joint.
// ----------------------------------------------------------------------------
// Usage: one input word per control tick carries the command and the measured
// position, velocity and torque (Q16.16). Each word yields exactly one result
// word with the motor target, body position, homed flag and status.
// Both data channels use valid/stall; a word moves when valid is high and
// stall is low. Registers are written over the cfg channel (cfg_ready is
// always high) and should only change while no word is in flight.
// A taken word passes the front register, the queue, then back-end stages s1 and s2.
// Throughput: one word per cycle while no stall holds the flow; the homed state,
// velocity window and running sum update once per word in the back end.
// A four-word queue between front and back end absorbs output stalls; the
// input stalls only when that queue and the front register are full.
// Reset clears all registers to their defaults, fills the velocity window
// with 1000.0, clears the homed flag and home position, and empties the
// pipeline. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module rotary_joint_stall_homing
	import rjsh_pkg::*;
#(
	parameter int WINDOW_LEN = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] measured_position,
	input  logic signed [31:0] measured_velocity,
	input  logic signed [31:0] measured_torque,
	input  logic signed [31:0] body_target,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] motor_target,
	output logic signed [31:0] body_position,
	output logic               homed,
	output logic [1:0]         status
);

	cfg_t     cfg_q;
	logic     q_full, q_empty, q_push, q_pop;
	q_entry_t q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.search_step      <= RST_SEARCH_STEP;
			cfg_q.stalled_step     <= RST_STALLED_STEP;
			cfg_q.torque_threshold <= RST_TORQUE_THRESH;
			cfg_q.stall_tolerance  <= RST_STALL_TOL;
			cfg_q.home_direction   <= 1'b1;
			cfg_q.cw_limit         <= '0;
			cfg_q.ccw_limit        <= '0;
			cfg_q.limit_margin     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SEARCH_STEP:   cfg_q.search_step      <= cfg_data[30:0];
				REG_STALLED_STEP:  cfg_q.stalled_step     <= cfg_data[30:0];
				REG_TORQUE_THRESH: cfg_q.torque_threshold <= cfg_data[30:0];
				REG_STALL_TOL:     cfg_q.stall_tolerance  <= cfg_data[30:0];
				REG_HOME_DIR:      cfg_q.home_direction   <= cfg_data[0];
				REG_CW_LIMIT:      cfg_q.cw_limit         <= cfg_data[30:0];
				REG_CCW_LIMIT:     cfg_q.ccw_limit        <= cfg_data[30:0];
				REG_LIMIT_MARGIN:  cfg_q.limit_margin     <= cfg_data[30:0];
				default:           cfg_q.limit_margin     <= cfg_q.limit_margin;
			endcase
		end
	end

	rjsh_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.command           (command),
		.measured_position (measured_position),
		.measured_velocity (measured_velocity),
		.measured_torque   (measured_torque),
		.body_target       (body_target),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_data            (q_wdata)
	);

	rjsh_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (q_rdata)
	);

	rjsh_back #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_data        (q_rdata),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.motor_target  (motor_target),
		.body_position (body_position),
		.homed         (homed),
		.status        (status)
	);

endmodule

// File: design/rjsh_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjsh_fifo
// Short queue of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module rjsh_fifo
	import rjsh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output q_entry_t pop_data
);

	q_entry_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;

	assign full     = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/rjsh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjsh_front
// Accepts input words, decodes the command, picks the search step and
// clamps the target, then hands a classified word to the queue.
// ----------------------------------------------------------------------------
module rjsh_front
	import rjsh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] measured_position,
	input  logic signed [31:0] measured_velocity,
	input  logic signed [31:0] measured_torque,
	input  logic signed [31:0] body_target,
	input  logic               q_full,
	output logic               q_push,
	output q_entry_t           q_data
);

	logic signed [33:0] cw_w, ccw_w, mg_w;
	logic signed [33:0] park, t_raw, t_clamp;
	logic [31:0]        atrq;
	logic [30:0]        step;
	cmd_t               kind;
	logic               accept;

	logic               valid_s1;
	cmd_t               kind_s1;
	logic signed [31:0] pos_s1;
	logic signed [31:0] vel_s1;
	logic [30:0]        step_s1;
	logic signed [33:0] t_s1;

	logic signed [34:0] pos_w, step_w;

	assign cw_w  = $signed({3'b000, cfg.cw_limit});
	assign ccw_w = $signed({3'b000, cfg.ccw_limit});
	assign mg_w  = $signed({3'b000, cfg.limit_margin});
	assign kind  = cmd_t'(command);

	always_comb begin
		park    = cfg.home_direction ? (ccw_w - mg_w) : -(cw_w + mg_w);
		t_raw   = (kind == CMD_MOVE) ? 34'(body_target) : park;
		t_clamp = t_raw;
		if (t_clamp > ccw_w) begin
			t_clamp = ccw_w - mg_w;
		end
		if (t_clamp < -cw_w) begin
			t_clamp = mg_w - cw_w;
		end
		atrq = measured_torque[31] ? -$unsigned(measured_torque) : $unsigned(measured_torque);
		step = (atrq > {1'b0, cfg.torque_threshold}) ? cfg.stalled_step : cfg.search_step;
	end

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			pos_s1  <= measured_position;
			vel_s1  <= measured_velocity;
			step_s1 <= step;
			t_s1    <= t_clamp;
		end
	end

	// Frame offsets relative to home; the back end adds home_position to rel and subtracts it from pos_off.
	always_comb begin
		pos_w  = 35'(pos_s1);
		step_w = $signed({4'b0000, step_s1});
		q_data.kind         = kind_s1;
		q_data.pos          = pos_s1;
		q_data.vel          = vel_s1;
		q_data.search_motor = sat32(cfg.home_direction ? (pos_w + step_w) : (pos_w - step_w));
		q_data.rel          = cfg.home_direction ? (t_s1 - ccw_w) : (t_s1 + cw_w);
		q_data.pos_off      = cfg.home_direction ? (34'(pos_s1) + ccw_w) : (34'(pos_s1) - cw_w);
	end

endmodule

// File: design/rjsh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjsh_back
// Carries out queued words: velocity window, stall test, homed state,
// then the final frame mapping into the output register.
// ----------------------------------------------------------------------------
module rjsh_back
	import rjsh_pkg::*;
#(
	parameter int WINDOW_LEN = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_empty,
	input  q_entry_t           q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] motor_target,
	output logic signed [31:0] body_position,
	output logic               homed,
	output logic [1:0]         status
);

	localparam int SW = 33 + $clog2(WINDOW_LEN);
	localparam logic signed [SW-1:0] SUM_INIT = SW'(WINDOW_LEN) * SW'(INIT_SPEED);

	logic signed [31:0]   win_q [WINDOW_LEN];
	logic signed [SW-1:0] sum_q;
	logic                 homed_q;
	logic signed [31:0]   home_q;

	logic signed [SW-1:0] sum_push, tol_s;
	logic                 stall_hit, do_push, homed_n;
	logic signed [31:0]   home_n;
	msel_t                sel_n;
	status_t              status_n;
	logic                 en;

	logic                 valid_s1;
	msel_t                sel_s1;
	status_t              status_s1;
	logic                 homed_s1;
	logic signed [31:0]   home_s1;
	logic signed [31:0]   search_s1;
	logic signed [33:0]   rel_s1;
	logic signed [33:0]   pos_off_s1;

	logic                 valid_s2;
	logic signed [31:0]   motor_s2;
	logic signed [31:0]   body_s2;
	logic                 homed_s2;
	status_t              status_s2;

	// The whole back end advances together whenever the output can move.
	assign en    = !valid_s2 || !out_stall;
	assign q_pop = en && !q_empty;

	assign sum_push  = sum_q - SW'(win_q[0]) + SW'(q_data.vel);
	assign tol_s     = $signed(SW'(cfg.stall_tolerance) * SW'(WINDOW_LEN));
	assign stall_hit = (sum_push < tol_s) && (sum_push > -tol_s);

	always_comb begin
		do_push  = 1'b0;
		homed_n  = homed_q;
		home_n   = home_q;
		sel_n    = MSEL_ZERO;
		status_n = ST_OK;
		case (q_data.kind)
			CMD_HOME: begin
				if (homed_q) begin
					sel_n    = MSEL_MAP;
					status_n = ST_PARK;
				end else if (q_data.pos == 32'sd0) begin
					status_n = ST_DISC;
				end else begin
					do_push = 1'b1;
					sel_n   = MSEL_SEARCH;
					if (stall_hit) begin
						homed_n  = 1'b1;
						home_n   = q_data.pos;
						status_n = ST_OK;
					end else begin
						status_n = ST_SEARCH;
					end
				end
			end
			CMD_MOVE: begin
				sel_n = MSEL_MAP;
			end
			CMD_CLEAR: begin
				homed_n = 1'b0;
			end
			default: begin
				sel_n = MSEL_ZERO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= INIT_SPEED;
			end
			sum_q   <= SUM_INIT;
			homed_q <= 1'b0;
			home_q  <= 32'sd0;
		end else if (q_pop) begin
			if (do_push) begin
				for (int i = 0; i < WINDOW_LEN - 1; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[WINDOW_LEN - 1] <= q_data.vel;
				sum_q <= sum_push;
			end
			homed_q <= homed_n;
			home_q  <= home_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= !q_empty;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sel_s1     <= sel_n;
			status_s1  <= status_n;
			homed_s1   <= homed_n;
			home_s1    <= home_n;
			search_s1  <= q_data.search_motor;
			rel_s1     <= q_data.rel;
			pos_off_s1 <= q_data.pos_off;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			case (sel_s1)
				MSEL_MAP:    motor_s2 <= sat32(35'(home_s1) + 35'(rel_s1));
				MSEL_SEARCH: motor_s2 <= search_s1;
				default:     motor_s2 <= 32'sd0;
			endcase
			body_s2   <= sat32(35'(pos_off_s1) - 35'(home_s1));
			homed_s2  <= homed_s1;
			status_s2 <= status_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign motor_target  = motor_s2;
	assign body_position = body_s2;
	assign homed         = homed_s2;
	assign status        = status_s2;

endmodule

// File: design/rjsh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjsh_checker
// Port-level checks on the result channel of the stall homing joint.
// ----------------------------------------------------------------------------
`include "rotary_joint_stall_homing_assert.svh"

module rjsh_checker
	import rjsh_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] motor_target,
	input logic signed [31:0] body_position,
	input logic               homed,
	input logic [1:0]         status
);

	// A stalled result word must be held unchanged.
	`RJSH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(motor_target) && $stable(body_position) && $stable(homed) && $stable(status), "result word changed while stalled")

	// A disconnect is only reported while unhomed and commands a zero target.
	`RJSH_ASSERT_SAME(a_disc_unhomed, clk, arst_n, out_valid && status == ST_DISC, !homed && motor_target == 32'sd0, "disconnect reported with homed flag or nonzero target")

	// Still searching means the stall test did not pass.
	`RJSH_ASSERT_SAME(a_search_unhomed, clk, arst_n, out_valid && status == ST_SEARCH, !homed, "searching status with homed flag set")

	// Parking only happens on an already homed joint.
	`RJSH_ASSERT_SAME(a_park_homed, clk, arst_n, out_valid && status == ST_PARK, homed, "parking status without homed flag")

endmodule

bind rotary_joint_stall_homing rjsh_checker u_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rotary_joint_stall_homing. A table of hand-picked
// words covers disconnects, step selection, saturation, stall detection,
// parking, moves and clears. Randomized phases with fresh register settings
// and varying backpressure follow. Every result word is compared against the
// table's expected word or an in-bench prediction of the joint.
// ----------------------------------------------------------------------------
module testbench;
	import rjsh_pkg::*;

	localparam int WIN_LEN      = 8;
	localparam int N_PHASES     = 9;
	localparam int PHASE_LEN    = 86;
	localparam int PRINT_CAP    = 40;
	localparam int SET_ALL_ZERO = 0;
	localparam int SET_ALL_MAX  = 1;
	localparam int SET_RANDOM   = 2;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] trq;
		logic signed [31:0] tgt;
	} joint_word_t;

	typedef struct packed {
		logic signed [31:0] motor;
		logic signed [31:0] body;
		logic               homed;
		status_t            status;
	} joint_result_t;

	typedef struct packed {
		joint_word_t   word;
		logic          typed;
		joint_result_t res;
	} table_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         command;
	logic signed [31:0] measured_position;
	logic signed [31:0] measured_velocity;
	logic signed [31:0] measured_torque;
	logic signed [31:0] body_target;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] motor_target;
	logic signed [31:0] body_position;
	logic               homed;
	logic [1:0]         status;

	// Predicted joint state and register copy.
	logic [30:0] step_search, step_stalled, trq_limit, stall_tol;
	logic [30:0] lim_cw, lim_ccw, margin;
	logic        dir_ccw;
	longint      vel_window [WIN_LEN];
	longint      vel_sum;
	logic        homed_q;
	longint      home_pos;

	joint_result_t response_fifo [$];
	table_row_t    directed_rows [24];
	int            mismatch_count = 0;
	int            send_idle_pct;
	int            recv_stall_pct;

	rotary_joint_stall_homing #(
		.WINDOW_LEN(WIN_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.measured_position(measured_position),
		.measured_velocity(measured_velocity),
		.measured_torque(measured_torque),
		.body_target(body_target),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.motor_target(motor_target),
		.body_position(body_position),
		.homed(homed),
		.status(status)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("** rotary_joint_stall_homing: FAILED **");
		$finish;
	end

	task automatic model_reset();
		step_search  = RST_SEARCH_STEP;
		step_stalled = RST_STALLED_STEP;
		trq_limit    = RST_TORQUE_THRESH;
		stall_tol    = RST_STALL_TOL;
		dir_ccw      = 1'b1;
		lim_cw       = '0;
		lim_ccw      = '0;
		margin       = '0;
		for (int i = 0; i < WIN_LEN; i++) begin
			vel_window[i] = 65536000;
		end
		vel_sum  = 65536000 * WIN_LEN;
		homed_q  = 1'b0;
		home_pos = 0;
	endtask

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint body_to_motor(input longint t);
		longint ccw, cw, mg;
		ccw = lim_ccw;
		cw  = lim_cw;
		mg  = margin;
		if (t > ccw) begin
			t = ccw - mg;
		end
		if (t < -cw) begin
			t = -cw + mg;
		end
		if (dir_ccw) begin
			return clip32(home_pos - (ccw - t));
		end
		return clip32(home_pos + (t + cw));
	endfunction

	// Advances the predicted joint by one input word and returns its result.
	function automatic joint_result_t joint_response(input joint_word_t w);
		longint        pos, vel, trq, atrq, step, asum, motor, body, park;
		joint_result_t r;
		pos      = w.pos;
		vel      = w.vel;
		trq      = w.trq;
		motor    = 0;
		r.status = ST_OK;
		case (w.cmd)
			CMD_HOME: begin
				if (homed_q) begin
					park = dir_ccw ? longint'(lim_ccw) - longint'(margin)
						: -(longint'(lim_cw) + longint'(margin));
					motor    = body_to_motor(park);
					r.status = ST_PARK;
				end else if (pos == 0) begin
					r.status = ST_DISC;
				end else begin
					atrq  = (trq < 0) ? -trq : trq;
					step  = (atrq > longint'(trq_limit)) ? longint'(step_stalled)
						: longint'(step_search);
					motor = clip32(dir_ccw ? pos + step : pos - step);
					vel_sum -= vel_window[0];
					for (int i = 0; i < WIN_LEN - 1; i++) begin
						vel_window[i] = vel_window[i + 1];
					end
					vel_window[WIN_LEN - 1] = vel;
					vel_sum += vel;
					asum = (vel_sum < 0) ? -vel_sum : vel_sum;
					if (asum < longint'(stall_tol) * WIN_LEN) begin
						homed_q  = 1'b1;
						home_pos = pos;
					end else begin
						r.status = ST_SEARCH;
					end
				end
			end
			CMD_MOVE: begin
				motor = body_to_motor(longint'(w.tgt));
			end
			CMD_CLEAR: begin
				homed_q = 1'b0;
			end
			default: begin
			end
		endcase
		if (dir_ccw) begin
			body = clip32(pos - home_pos + longint'(lim_ccw));
		end else begin
			body = clip32(pos - home_pos - longint'(lim_cw));
		end
		r.motor = motor[31:0];
		r.body  = body[31:0];
		r.homed = homed_q;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	task automatic check_result();
		joint_result_t e;
		if (response_fifo.size() == 0) begin
			report_mismatch($sformatf("result word with none pending, motor_target %0d",
				motor_target));
			return;
		end
		e = response_fifo.pop_front();
		if (motor_target !== e.motor) begin
			report_mismatch($sformatf("motor_target %0d, expected %0d", motor_target, e.motor));
		end
		if (body_position !== e.body) begin
			report_mismatch($sformatf("body_position %0d, expected %0d", body_position, e.body));
		end
		if (homed !== e.homed) begin
			report_mismatch($sformatf("homed %0b, expected %0b", homed, e.homed));
		end
		if (status !== e.status) begin
			report_mismatch($sformatf("status %0d, expected %0d", status, e.status));
		end
	endtask

	// Result side: check at each accepted word, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			check_result();
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SEARCH_STEP:   step_search  = data[30:0];
			REG_STALLED_STEP:  step_stalled = data[30:0];
			REG_TORQUE_THRESH: trq_limit    = data[30:0];
			REG_STALL_TOL:     stall_tol    = data[30:0];
			REG_HOME_DIR:      dir_ccw      = data[0];
			REG_CW_LIMIT:      lim_cw       = data[30:0];
			REG_CCW_LIMIT:     lim_ccw      = data[30:0];
			REG_LIMIT_MARGIN:  margin       = data[30:0];
			default: begin
			end
		endcase
	endtask

	function automatic logic [31:0] pick_setting(input int kind, input reg_idx_t idx);
		logic [31:0] r;
		r = $urandom;
		if (kind == SET_ALL_ZERO) begin
			return 32'h0;
		end
		// Bit 31 is set on purpose so that the width masking is exercised.
		if (kind == SET_ALL_MAX) begin
			return 32'hFFFF_FFFF;
		end
		case (idx)
			REG_SEARCH_STEP, REG_STALLED_STEP:
				return ($urandom_range(3) == 0) ? r : 32'($urandom_range(200000));
			REG_TORQUE_THRESH:
				return ($urandom_range(3) == 0) ? r : 32'($urandom_range(300000));
			REG_STALL_TOL:
				return ($urandom_range(7) == 0) ? r : 32'($urandom_range(60000, 1000));
			REG_HOME_DIR:
				return r;
			default:
				return ($urandom_range(3) == 0) ? r : 32'($urandom_range(20000000));
		endcase
	endfunction

	task automatic configure(input int kind);
		reg_idx_t idx;
		idx = idx.first();
		do begin
			write_reg(idx, pick_setting(kind, idx));
			idx = idx.next();
		end while (idx != idx.first());
		cfg_valid <= 1'b0;
	endtask

	// Holds the sender off until every pending result word has come back.
	task automatic wait_until_settled();
		in_valid <= 1'b0;
		while (response_fifo.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_word(input joint_word_t w, input logic typed,
			input joint_result_t typed_res);
		joint_result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid          <= 1'b1;
		command           <= w.cmd;
		measured_position <= w.pos;
		measured_velocity <= w.vel;
		measured_torque   <= w.trq;
		body_target       <= w.tgt;
		do @(posedge clk); while (in_stall);
		r = joint_response(w);
		response_fifo.push_back(typed ? typed_res : r);
	endtask

	// Mostly homing runs whose velocity settles inside the tolerance, so that
	// stalls are detected regularly; the rest is moves, clears and noise.
	function automatic joint_word_t next_word();
		joint_word_t w;
		int          sel;
		int          half;
		sel = $urandom_range(99);
		if (!homed_q) begin
			w.cmd = (sel < 75) ? CMD_HOME : (sel < 85) ? CMD_MOVE
				: (sel < 93) ? CMD_CLEAR : CMD_NONE;
		end else begin
			w.cmd = (sel < 35) ? CMD_HOME : (sel < 75) ? CMD_MOVE
				: (sel < 92) ? CMD_CLEAR : CMD_NONE;
		end

		sel = $urandom_range(99);
		if (sel < 5) begin
			w.pos = '0;
		end else if (sel < 30) begin
			w.pos = $urandom;
		end else begin
			w.pos = $urandom_range(33554432) - 32'd16777216;
		end

		half = (stall_tol > 31'd1048576) ? 524288 : int'(stall_tol) / 2;
		if ($urandom_range(99) < 85) begin
			w.vel = $urandom_range(2 * half) - half;
		end else begin
			w.vel = $urandom;
		end

		if ($urandom_range(99) < 35) begin
			w.trq = trq_limit + $urandom_range(2) - 1;
			if ($urandom_range(1) == 1) begin
				w.trq = -w.trq;
			end
		end else begin
			w.trq = $urandom;
		end

		sel = $urandom_range(99);
		if (sel < 18) begin
			w.tgt = 32'(longint'(lim_ccw) + $urandom_range(2000) - 1000);
		end else if (sel < 35) begin
			w.tgt = 32'(-longint'(lim_cw) + $urandom_range(2000) - 1000);
		end else if (sel < 65) begin
			w.tgt = $urandom;
		end else begin
			w.tgt = $urandom_range(67108864) - 32'd33554432;
		end
		return w;
	endfunction

	initial begin
		joint_word_t   w;
		joint_result_t none;
		arst_n            = 1'b0;
		cfg_valid         = 1'b0;
		cfg_index         = REG_SEARCH_STEP;
		cfg_data          = '0;
		in_valid          = 1'b0;
		command           = CMD_HOME;
		measured_position = '0;
		measured_velocity = '0;
		measured_torque   = '0;
		body_target       = '0;
		send_idle_pct     = 37;
		recv_stall_pct    = 84;
		none              = '0;
		model_reset();

		// Register defaults hold throughout this table. Until the first homing, every
		// homing tick with a nonzero position pushes zero velocity, so the eighth one homes.
		directed_rows = '{
			'{'{CMD_HOME, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
				'{32'sd0, 32'sd0, 1'b0, ST_DISC}},
			'{'{CMD_HOME, 32'sd65536, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
				'{32'sd72090, 32'sd65536, 1'b0, ST_SEARCH}},
			'{'{CMD_HOME, 32'sd100, 32'sd0, 32'sd65536, 32'sd0}, 1'b1,
				'{32'sd6654, 32'sd100, 1'b0, ST_SEARCH}},
			'{'{CMD_HOME, 32'sd100, 32'sd0, 32'sd65537, 32'sd0}, 1'b1,
				'{32'sd1036, 32'sd100, 1'b0, ST_SEARCH}},
			'{'{CMD_HOME, 32'sd100, 32'sd0, -32'sd65537, 32'sd0}, 1'b1,
				'{32'sd1036, 32'sd100, 1'b0, ST_SEARCH}},
			'{'{CMD_HOME, 32'sh7FFF_FFFF, 32'sd0, 32'sh8000_0000, 32'sd0}, 1'b1,
				'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, ST_SEARCH}},
			'{'{CMD_HOME, 32'sh8000_0000, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
				'{32'sh8000_199A, 32'sh8000_0000, 1'b0, ST_SEARCH}},
			'{'{CMD_MOVE, 32'sd12345, 32'sd0, 32'sd0, 32'sh7FFF_FFFF}, 1'b1,
				'{32'sd0, 32'sd12345, 1'b0, ST_OK}},
			'{'{CMD_MOVE, 32'sd1, 32'sd0, 32'sd0, 32'sh8000_0000}, 1'b1,
				'{32'sd0, 32'sd1, 1'b0, ST_OK}},
			'{'{CMD_NONE, -32'sd5, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd77}, 1'b1,
				'{32'sd0, -32'sd5, 1'b0, ST_OK}},
			'{'{CMD_CLEAR, 32'sd0, 32'sh8000_0000, 32'sd0, 32'sd0}, 1'b1,
				'{32'sd0, 32'sd0, 1'b0, ST_OK}},
			'{'{CMD_HOME, 32'sd1000, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
				'{32'sd7554, 32'sd1000, 1'b0, ST_SEARCH}},
			'{'{CMD_HOME, 32'sd0, 32'sh7FFF_FFFF, 32'sd0, 32'sd0}, 1'b1,
				'{32'sd0, 32'sd0, 1'b0, ST_DISC}},
			'{'{CMD_HOME, 32'sd200000, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
				'{32'sd206554, 32'sd0, 1'b1, ST_OK}},
			'{'{CMD_HOME, 32'sd5, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd0}, 1'b1,
				'{32'sd200000, -32'sd199995, 1'b1, ST_PARK}},
			'{'{CMD_MOVE, 32'sd200000, 32'sd0, 32'sd0, 32'sd65536}, 1'b1,
				'{32'sd200000, 32'sd0, 1'b1, ST_OK}},
			'{'{CMD_MOVE, 32'sh7FFF_FFFF, 32'sd0, 32'sd0, -32'sd1}, 1'b1,
				'{32'sd200000, 32'sd2147283647, 1'b1, ST_OK}},
			'{'{CMD_HOME, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
				'{32'sd200000, -32'sd200000, 1'b1, ST_PARK}},
			'{'{CMD_CLEAR, 32'sd300000, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
				'{32'sd0, 32'sd100000, 1'b0, ST_OK}},
			'{'{CMD_HOME, -32'sd300000, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
				'{-32'sd293446, 32'sd0, 1'b1, ST_OK}},
			'{'{CMD_CLEAR, 32'sh7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
			'{'{CMD_HOME, 32'sh5555_5555, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
				32'shAAAA_AAAA}, 1'b0, '0},
			'{'{CMD_HOME, 32'shAAAA_AAAA, 32'sh8000_0000, 32'sh8000_0000,
				32'sh5555_5555}, 1'b0, '0},
			'{'{CMD_MOVE, -32'sd1, 32'sd0, 32'sd0, 32'sh1234_5678}, 1'b0, '0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(directed_rows); i++) begin
			send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			wait_until_settled();
			case (p / 3)
				0: begin
					send_idle_pct  = 37;
					recv_stall_pct = 84;
				end
				1: begin
					send_idle_pct  = 84;
					recv_stall_pct = 37;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			configure((p == 1) ? SET_ALL_MAX : (p == 5) ? SET_ALL_ZERO : SET_RANDOM);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (p == 3 && n == PHASE_LEN / 2) begin
					wait_until_settled();
				end
				w = next_word();
				send_word(w, 1'b0, none);
			end
		end

		wait_until_settled();
		if (mismatch_count == 0) begin
			$display("** rotary_joint_stall_homing: PASSED **");
		end else begin
			$display("** rotary_joint_stall_homing: FAILED **");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/rjsh_pkg.sv
design/rjsh_fifo.sv
design/rjsh_front.sv
design/rjsh_back.sv
design/rotary_joint_stall_homing.sv
design/rjsh_checker.sv
verif/testbench.sv
